// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros used by the checker file of the project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked in the cycle after a trigger condition.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hdl/lfo_pkg.sv =====
// ---------------------------------------------------------------------------
// lfo_pkg
// Types, constants and the arctangent table of the LFO sample modulator.
// ---------------------------------------------------------------------------
package lfo_pkg;

    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int PHASE_BITS_DEF    = 32;
    localparam int POSITION_BITS_DEF = 20;

    localparam int PERIOD_LEN_RST = 44100;
    localparam int PHASE_STEP_RST = 97391;

    // CORDIC datapath: x and y carry 34 fraction bits, the angle is in 2^-32 turn.
    localparam int CORDIC_ITERS = 24;
    localparam int ITER_BITS    = $clog2(CORDIC_ITERS);
    localparam int CORDIC_FRAC  = 34;
    localparam int CORDIC_W     = 38;
    localparam int ANGLE_W      = 32;
    localparam int ATAN_W       = 30;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INV = 38'sd10432525985;

    localparam int CFG_INDEX_BITS = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PERIOD_LEN = 2'd0,
        CFG_PHASE_STEP = 2'd1,
        CFG_INIT_PHASE = 2'd2,
        CFG_WAVEFORM   = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_ADD  = 2'd1,
        OP_SUB  = 2'd2,
        OP_PASS = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quadrant;

    typedef struct packed {
        logic      start;
        t_quadrant quad;
    } t_cordic_ctrl;

    function automatic logic [ATAN_W-1:0] atan_turns(input logic [ITER_BITS-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/lfo_cordic.sv =====
// ---------------------------------------------------------------------------
// lfo_cordic
// Iterative rotation-mode CORDIC: one shift-add stage reused for every iteration,
// then the result is mapped back to the quadrant of the input phase.
// ---------------------------------------------------------------------------
module lfo_cordic (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lfo_pkg::t_cordic_ctrl                i_ctrl,
    input  logic [lfo_pkg::ATAN_W-1:0]           i_angle,
    output logic                                 o_done,
    output logic signed [lfo_pkg::CORDIC_W-1:0]  o_value
);

    localparam int CW = lfo_pkg::CORDIC_W;
    localparam int AW = lfo_pkg::ANGLE_W;
    localparam int IW = lfo_pkg::ITER_BITS;

    logic signed [CW-1:0] r_x, r_y, n_x, n_y;
    logic signed [AW-1:0] r_z, n_z;
    logic [IW-1:0]        r_iter;
    logic                 r_busy;
    logic                 r_done;
    lfo_pkg::t_quadrant   r_quad;

    logic signed [CW-1:0] dx, dy;
    logic signed [AW-1:0] atan_ext;

    always_comb begin
        dx       = r_y >>> r_iter;
        dy       = r_x >>> r_iter;
        atan_ext = signed'({{(AW - lfo_pkg::ATAN_W){1'b0}}, lfo_pkg::atan_turns(r_iter)});
        if (!r_z[AW-1]) begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - atan_ext;
        end else begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + atan_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                if (r_iter == IW'(lfo_pkg::CORDIC_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_iter <= r_iter + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_x    <= lfo_pkg::CORDIC_GAIN_INV;
            r_y    <= '0;
            r_z    <= signed'({{(AW - lfo_pkg::ATAN_W){1'b0}}, i_angle});
            r_quad <= i_ctrl.quad;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    // The rotation covers one quadrant; the others follow by symmetry.
    always_comb begin
        case (r_quad)
            lfo_pkg::QUAD_0: o_value = r_x;
            lfo_pkg::QUAD_1: o_value = -r_y;
            lfo_pkg::QUAD_2: o_value = -r_x;
            default:         o_value = r_y;
        endcase
    end

    assign o_done = r_done;

endmodule

// ===== hdl/lfo_sample_modulator_core.sv =====
// Sequence: a sine word waits in S_ROTATE for the CORDIC (24 passes through
// its single shift-add stage), a square word skips it; both then go through
// S_ROUND, S_MUL and S_DONE, which loads the output register once it is free.
// A new word is taken only in S_IDLE, after the last one has left S_DONE.
// Reset: synchronous, active low; control registers return to their defaults,
// position to zero and the phase to the start phase. No memory, no clearing pass.
// ---------------------------------------------------------------------------
// lfo_sample_modulator_core
// Tremolo: combines each audio word with a sine or square oscillator value by
// multiply, add or subtract, or passes it unchanged, with saturation and a clip flag.
// ---------------------------------------------------------------------------
module lfo_sample_modulator_core #(
    parameter int SAMPLE_BITS   = lfo_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_BITS    = lfo_pkg::PHASE_BITS_DEF,
    parameter int POSITION_BITS = lfo_pkg::POSITION_BITS_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    // configuration write channel
    input  logic                                           i_cfg_valid,
    output logic                                           o_cfg_ready,
    input  logic [lfo_pkg::CFG_INDEX_BITS-1:0]             i_cfg_index,
    input  logic [(PHASE_BITS > POSITION_BITS ? PHASE_BITS : POSITION_BITS)-1:0] i_cfg_data,
    // input channel
    input  logic                                           i_in_valid,
    output logic                                           o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]                  i_sample_in,
    input  logic [1:0]                                     i_opcode,
    input  logic                                           i_rectify,
    // output channel
    output logic                                           o_out_valid,
    input  logic                                           i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]                  o_sample_out,
    output logic                                           o_clipped
);

    localparam int FRAC     = SAMPLE_BITS - 1;
    localparam int OSC_W    = SAMPLE_BITS + 1;
    localparam int PROD_W   = OSC_W + SAMPLE_BITS;
    localparam int PSUM_W   = PROD_W + 1;
    localparam int ACC_W    = SAMPLE_BITS + 2;
    localparam int RND_SH   = lfo_pkg::CORDIC_FRAC - FRAC;
    localparam int RND_W    = lfo_pkg::CORDIC_W + 1;
    localparam int POS1_W   = POSITION_BITS + 1;
    localparam int AW       = lfo_pkg::ANGLE_W;

    localparam logic signed [OSC_W-1:0] OSC_FULL  = {2'b01, {FRAC{1'b0}}};
    localparam logic signed [OSC_W-1:0] OSC_NFULL = {2'b11, {FRAC{1'b0}}};
    localparam logic signed [RND_W-1:0] RND_FULL  = {{(RND_W - OSC_W){1'b0}}, OSC_FULL};
    localparam logic signed [RND_W-1:0] RND_NFULL = {{(RND_W - OSC_W){1'b1}}, OSC_NFULL};
    localparam logic signed [RND_W-1:0] RND_HALF  = RND_W'(1) <<< (RND_SH - 1);
    localparam logic signed [PSUM_W-1:0] PROD_HALF = PSUM_W'(1) <<< (FRAC - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX   = {3'b000, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN   = {3'b111, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ROTATE = 5'b00010,
        S_ROUND  = 5'b00100,
        S_MUL    = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // configuration and oscillator state
    logic [POSITION_BITS-1:0] r_period_len;
    logic [PHASE_BITS-1:0]    r_phase_step;
    logic [PHASE_BITS-1:0]    r_init_phase;
    logic                     r_waveform;
    logic [POSITION_BITS-1:0] r_position;
    logic [PHASE_BITS-1:0]    r_phase_acc;

    // per-word working registers
    logic signed [SAMPLE_BITS-1:0] r_sample;
    lfo_pkg::t_opcode              r_opcode;
    logic                          r_rectify;
    logic                          r_is_square;
    logic signed [OSC_W-1:0]       r_square_val;
    logic signed [OSC_W-1:0]       r_osc, n_osc;
    logic signed [PROD_W-1:0]      r_prod;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample_out;
    logic                          r_clipped;

    logic in_fire, out_fire, cfg_fire, out_load;

    logic [PHASE_BITS+AW-1:0] phase_wide;
    logic [AW-1:0]            turn;
    lfo_pkg::t_quadrant       quad;
    logic signed [OSC_W-1:0]  square_val;

    lfo_pkg::t_cordic_ctrl             cordic_ctrl;
    logic                              cordic_done;
    logic signed [lfo_pkg::CORDIC_W-1:0] cordic_value;

    logic signed [RND_W-1:0]  rnd_sum, rnd_shift;
    logic signed [OSC_W-1:0]  osc_clamped, osc_pre;

    logic signed [PSUM_W-1:0] prod_sum, prod_shift;
    logic signed [ACC_W-1:0]  osc_ext, s_ext, res;
    logic signed [SAMPLE_BITS-1:0] n_sample_out;
    logic                     n_clipped;

    logic [POS1_W-1:0] pos_inc, plen;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = r_out_valid && i_out_ready;
    assign cfg_fire = i_cfg_valid && o_cfg_ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Top 32 phase bits as a fraction of one turn.
    always_comb begin
        phase_wide = {r_phase_acc, {AW{1'b0}}};
        turn       = phase_wide[PHASE_BITS+AW-1 -: AW];
        quad       = lfo_pkg::t_quadrant'(turn[AW-1 -: 2]);
        if (turn == 32'h4000_0000 || turn == 32'hC000_0000) begin
            square_val = '0;
        end else begin
            case (quad) inside
                lfo_pkg::QUAD_0, lfo_pkg::QUAD_3: square_val = OSC_FULL;
                default:                          square_val = OSC_NFULL;
            endcase
        end
    end

    assign cordic_ctrl.start = in_fire && !r_waveform;
    assign cordic_ctrl.quad  = quad;

    lfo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (cordic_ctrl),
        .i_angle (turn[lfo_pkg::ATAN_W-1:0]),
        .o_done  (cordic_done),
        .o_value (cordic_value)
    );

    // Round the Q34 CORDIC result to the sample fraction and clamp to +-1.0.
    always_comb begin
        rnd_sum   = RND_W'(cordic_value) + RND_HALF;
        rnd_shift = rnd_sum >>> RND_SH;
        if (rnd_shift > RND_FULL) begin
            osc_clamped = OSC_FULL;
        end else if (rnd_shift < RND_NFULL) begin
            osc_clamped = OSC_NFULL;
        end else begin
            osc_clamped = signed'(rnd_shift[OSC_W-1:0]);
        end
        osc_pre = r_is_square ? r_square_val : osc_clamped;
        n_osc   = (r_rectify && osc_pre[OSC_W-1]) ? -osc_pre : osc_pre;
    end

    // Combine and saturate.
    always_comb begin
        prod_sum   = PSUM_W'(r_prod) + PROD_HALF;
        prod_shift = prod_sum >>> FRAC;
        osc_ext    = ACC_W'(r_osc);
        s_ext      = ACC_W'(r_sample);
        case (r_opcode)
            lfo_pkg::OP_MUL: res = signed'(prod_shift[ACC_W-1:0]);
            lfo_pkg::OP_ADD: res = osc_ext + s_ext;
            lfo_pkg::OP_SUB: res = osc_ext - s_ext;
            default:         res = s_ext;
        endcase
        if (res > SAT_MAX) begin
            n_sample_out = SAT_MAX[SAMPLE_BITS-1:0];
            n_clipped    = 1'b1;
        end else if (res < SAT_MIN) begin
            n_sample_out = SAT_MIN[SAMPLE_BITS-1:0];
            n_clipped    = 1'b1;
        end else begin
            n_sample_out = res[SAMPLE_BITS-1:0];
            n_clipped    = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = r_waveform ? S_ROUND : S_ROTATE;
                end
            end
            S_ROTATE: begin
                if (cordic_done) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: n_state = S_MUL;
            S_MUL:   n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        pos_inc = POS1_W'(r_position) + POS1_W'(1);
        plen    = (r_period_len == '0) ? POS1_W'(1) : POS1_W'(r_period_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_period_len <= POSITION_BITS'(lfo_pkg::PERIOD_LEN_RST);
            r_phase_step <= PHASE_BITS'(lfo_pkg::PHASE_STEP_RST);
            r_init_phase <= '0;
            r_waveform   <= 1'b0;
            r_position   <= '0;
            r_phase_acc  <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
            // Any register write restarts the oscillator at the start phase.
            if (cfg_fire) begin
                r_position <= '0;
                if (lfo_pkg::t_cfg_index'(i_cfg_index) == lfo_pkg::CFG_INIT_PHASE) begin
                    r_phase_acc <= i_cfg_data[PHASE_BITS-1:0];
                end else begin
                    r_phase_acc <= r_init_phase;
                end
                unique case (lfo_pkg::t_cfg_index'(i_cfg_index))
                    lfo_pkg::CFG_PERIOD_LEN: r_period_len <= i_cfg_data[POSITION_BITS-1:0];
                    lfo_pkg::CFG_PHASE_STEP: r_phase_step <= i_cfg_data[PHASE_BITS-1:0];
                    lfo_pkg::CFG_INIT_PHASE: r_init_phase <= i_cfg_data[PHASE_BITS-1:0];
                    lfo_pkg::CFG_WAVEFORM:   r_waveform   <= i_cfg_data[0];
                    default: ;
                endcase
            end else if (in_fire) begin
                if (pos_inc >= plen) begin
                    r_position  <= '0;
                    r_phase_acc <= r_init_phase;
                end else begin
                    r_position  <= pos_inc[POSITION_BITS-1:0];
                    r_phase_acc <= r_phase_acc + r_phase_step;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sample     <= i_sample_in;
            r_opcode     <= lfo_pkg::t_opcode'(i_opcode);
            r_rectify    <= i_rectify;
            r_is_square  <= r_waveform;
            r_square_val <= square_val;
        end
        if (r_state == S_ROUND) begin
            r_osc <= n_osc;
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(r_osc) * PROD_W'(r_sample);
        end
        if (out_load) begin
            r_sample_out <= n_sample_out;
            r_clipped    <= n_clipped;
        end
    end

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_clipped    = r_clipped;

endmodule

// ===== hdl/lfo_checker.sv =====
// ---------------------------------------------------------------------------
// lfo_checker
// Port-level checks of the LFO sample modulator, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lfo_checker #(
    parameter int SAMPLE_BITS = lfo_pkg::SAMPLE_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] o_sample_out,
    input logic                   o_clipped
);

    localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic               in_fire;
    logic               out_stall;
    logic               clip_ok;
    logic [SAMPLE_BITS:0] out_word;

    assign in_fire   = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;
    assign clip_ok   = !(o_out_valid && o_clipped)
                       || o_sample_out == S_MAX || o_sample_out == S_MIN;
    assign out_word  = {o_sample_out, o_clipped};

    // A word in progress blocks the input for at least the next cycle.
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_fire, !o_in_ready, "ready after accept")

    // A saturated word always sits at one of the two range limits.
    `ASSERT_CLK(a_clip_at_limit, i_clk, i_rst_n, clip_ok, "clip flag off range limit")

    `ASSERT_NEXT(a_out_valid_hold, i_clk, i_rst_n, out_stall, o_out_valid, "output valid dropped")

    `ASSERT_NEXT(a_out_data_hold, i_clk, i_rst_n, out_stall, $stable(out_word), "word changed")

endmodule

bind lfo_sample_modulator_core lfo_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_lfo_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_sample_out (o_sample_out),
    .o_clipped    (o_clipped)
);

// ===== bench/lfo_sample_modulator_checker.sv =====
// ---------------------------------------------------------------------------
// lfo_sample_modulator_checker
// Watches the register, input and output channels of the LFO sample
// modulator, predicts every output word and compares it field by field.
// ---------------------------------------------------------------------------
module lfo_sample_modulator_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  lfo_pkg::t_cfg_index                  i_cfg_index,
    input  logic [lfo_pkg::PHASE_BITS_DEF-1:0]   i_cfg_data,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic signed [lfo_pkg::SAMPLE_BITS_DEF-1:0] i_sample_in,
    input  logic [1:0]                           i_opcode,
    input  logic                                 i_rectify,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic signed [lfo_pkg::SAMPLE_BITS_DEF-1:0] i_sample_out,
    input  logic                                 i_clipped,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = lfo_pkg::SAMPLE_BITS_DEF;
    localparam int PW = lfo_pkg::PHASE_BITS_DEF;
    localparam int NW = lfo_pkg::POSITION_BITS_DEF;
    localparam int FB = SW - 1;
    localparam int RND_SH = lfo_pkg::CORDIC_FRAC - FB;

    localparam longint UNITY      = 64'sd1 <<< FB;
    localparam longint SAMPLE_MAX = UNITY - 1;
    localparam longint SAMPLE_MIN = -UNITY;
    localparam longint START_X    = 64'sd10432525985;

    // Arctangent of 2^-k, in units of 2^-32 turn.
    localparam longint ATAN_TURN [lfo_pkg::CORDIC_ITERS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087,
        667544, 333772, 166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic                 clip;
    } t_mod_word;

    logic [NW-1:0] period_len;
    logic [PW-1:0] phase_step;
    logic [PW-1:0] init_phase;
    logic          waveform;
    logic [NW-1:0] position;
    logic [PW-1:0] phase_acc;
    int            fail_total;
    t_mod_word     expected_words[$];

    always @(posedge i_clk) begin : track
        longint        smp;
        longint        lvl;
        longint        res;
        longint        cx;
        longint        cy;
        longint        cz;
        longint        dx;
        longint        dy;
        logic [NW:0]   next_pos;
        logic [NW-1:0] span;
        t_mod_word     want;

        if (!i_rst_n) begin
            period_len = NW'(lfo_pkg::PERIOD_LEN_RST);
            phase_step = PW'(lfo_pkg::PHASE_STEP_RST);
            init_phase = '0;
            waveform   = 1'b0;
            position   = '0;
            phase_acc  = '0;
            fail_total = 0;
            expected_words.delete();
        end else begin
            // Any register write restarts the oscillator.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    lfo_pkg::CFG_PERIOD_LEN: period_len = i_cfg_data[NW-1:0];
                    lfo_pkg::CFG_PHASE_STEP: phase_step = i_cfg_data[PW-1:0];
                    lfo_pkg::CFG_INIT_PHASE: init_phase = i_cfg_data[PW-1:0];
                    lfo_pkg::CFG_WAVEFORM:   waveform   = i_cfg_data[0];
                endcase
                position  = '0;
                phase_acc = init_phase;
            end

            if (i_in_valid && i_in_ready) begin
                if (waveform) begin
                    // The square wave is zero exactly at a quarter and three quarters.
                    if (phase_acc[PW-3:0] == '0 && phase_acc[PW-2])
                        lvl = 0;
                    else
                        lvl = (phase_acc[PW-1] == phase_acc[PW-2]) ? UNITY : -UNITY;
                end else begin
                    cx = START_X;
                    cy = 0;
                    cz = longint'(phase_acc[PW-3:0]);
                    for (int k = 0; k < lfo_pkg::CORDIC_ITERS; k++) begin
                        dx = cy >>> k;
                        dy = cx >>> k;
                        if (cz >= 0) begin
                            cx -= dx;
                            cy += dy;
                            cz -= ATAN_TURN[k];
                        end else begin
                            cx += dx;
                            cy -= dy;
                            cz += ATAN_TURN[k];
                        end
                    end
                    case (lfo_pkg::t_quadrant'(phase_acc[PW-1 -: 2]))
                        lfo_pkg::QUAD_0: lvl = cx;
                        lfo_pkg::QUAD_1: lvl = -cy;
                        lfo_pkg::QUAD_2: lvl = -cx;
                        lfo_pkg::QUAD_3: lvl = cy;
                    endcase
                    lvl = (lvl + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
                    if (lvl > UNITY)
                        lvl = UNITY;
                    if (lvl < -UNITY)
                        lvl = -UNITY;
                end

                if (i_rectify && lvl < 0)
                    lvl = -lvl;
                smp = longint'(i_sample_in);
                case (lfo_pkg::t_opcode'(i_opcode))
                    lfo_pkg::OP_MUL:  res = (lvl * smp + (64'sd1 <<< (FB - 1))) >>> FB;
                    lfo_pkg::OP_ADD:  res = lvl + smp;
                    lfo_pkg::OP_SUB:  res = lvl - smp;
                    lfo_pkg::OP_PASS: res = smp;
                endcase
                want.clip = 1'b0;
                if (res > SAMPLE_MAX) begin
                    res = SAMPLE_MAX;
                    want.clip = 1'b1;
                end
                if (res < SAMPLE_MIN) begin
                    res = SAMPLE_MIN;
                    want.clip = 1'b1;
                end
                want.sample = res[SW-1:0];
                expected_words.push_back(want);

                // A zero period behaves as a period of one.
                span = (period_len == '0) ? NW'(1) : period_len;
                next_pos = {1'b0, position} + 1'b1;
                if (next_pos >= {1'b0, span}) begin
                    position  = '0;
                    phase_acc = init_phase;
                end else begin
                    position  = next_pos[NW-1:0];
                    phase_acc = phase_acc + phase_step;
                end
            end

            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("output word with none expected: sample_out %0d clipped %0b",
                           i_sample_out, i_clipped);
                    fail_total++;
                end else begin
                    want = expected_words.pop_front();
                    if (i_sample_out !== want.sample) begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               want.sample, i_sample_out);
                        fail_total++;
                    end
                    if (i_clipped !== want.clip) begin
                        $error("clipped mismatch: expected %0b, actual %0b",
                               want.clip, i_clipped);
                        fail_total++;
                    end
                end
            end
        end

        o_pending    <= expected_words.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== bench/lfo_sample_modulator_core_tb.sv =====
// ---------------------------------------------------------------------------
// lfo_sample_modulator_core_tb
// Drives register writes and audio words into the LFO sample modulator under
// several idle and stall patterns and reports the verdict of the checker.
// ---------------------------------------------------------------------------
module lfo_sample_modulator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = lfo_pkg::SAMPLE_BITS_DEF;
    localparam int CW = lfo_pkg::PHASE_BITS_DEF;
    localparam int NW = lfo_pkg::POSITION_BITS_DEF;

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 78;
    localparam int HOLD_CYCLES     = 400;
    localparam int TAIL_CYCLES     = 40;
    localparam int LIMIT_NS        = 5_000_000;

    localparam logic signed [SW-1:0] SAMPLE_HI = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_LO = {1'b1, {(SW-1){1'b0}}};

    typedef struct {
        lfo_pkg::t_cfg_index idx;
        logic [CW-1:0]       data;
    } t_reg_write;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    lfo_pkg::t_cfg_index  i_cfg_index = lfo_pkg::CFG_PERIOD_LEN;
    logic [CW-1:0]        i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic signed [SW-1:0] i_sample_in = '0;
    logic [1:0]           i_opcode    = lfo_pkg::OP_MUL;
    logic                 i_rectify   = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic signed [SW-1:0] o_sample_out;
    logic                 o_clipped;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_req     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int fail_count;
    int pending;

    t_reg_write reg_writes[$];

    lfo_sample_modulator_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .i_opcode     (i_opcode),
        .i_rectify    (i_rectify),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped)
    );

    lfo_sample_modulator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .i_opcode     (i_opcode),
        .i_rectify    (i_rectify),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_sample_out (o_sample_out),
        .i_clipped    (o_clipped),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output side: random stalls, or a long hold-off whenever the stimulus asks
    // for one, so that the block fills up and stops taking words.
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic apply_writes();
        t_reg_write w;
        while (reg_writes.size() != 0) begin
            w = reg_writes.pop_front();
            i_cfg_valid <= 1'b1;
            i_cfg_index <= w.idx;
            i_cfg_data  <= w.data;
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Valid stays high into the next word unless an idle gap is drawn.
    task automatic send_word(input logic signed [SW-1:0] smp, input lfo_pkg::t_opcode op,
                             input logic rect);
        int gap;
        i_in_valid  <= 1'b1;
        i_sample_in <= smp;
        i_opcode    <= op;
        i_rectify   <= rect;
        do @(posedge i_clk); while (!o_in_ready);
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        logic [CW-1:0]        r;
        int                   mode;
        logic signed [SW-1:0] smp;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default settings: the oscillator starts near +1.0.
        send_word(SAMPLE_HI, lfo_pkg::OP_MUL, 1'b0);
        send_word(SAMPLE_LO, lfo_pkg::OP_MUL, 1'b0);
        send_word(SAMPLE_HI, lfo_pkg::OP_ADD, 1'b0);
        send_word(SAMPLE_LO, lfo_pkg::OP_ADD, 1'b1);
        send_word(SAMPLE_LO, lfo_pkg::OP_SUB, 1'b0);
        send_word(SAMPLE_HI, lfo_pkg::OP_SUB, 1'b1);
        send_word('0, lfo_pkg::OP_PASS, 1'b0);
        send_word(SAMPLE_LO, lfo_pkg::OP_PASS, 1'b1);
        send_word(-1, lfo_pkg::OP_MUL, 1'b1);
        send_word(1, lfo_pkg::OP_ADD, 1'b0);
        send_word('0, lfo_pkg::OP_SUB, 1'b0);
        drain();

        // Half a turn: -1.0 times -1.0 must saturate.
        reg_writes.push_back('{lfo_pkg::CFG_INIT_PHASE, 32'h8000_0000});
        apply_writes();
        send_word(SAMPLE_LO, lfo_pkg::OP_MUL, 1'b0);
        send_word(SAMPLE_LO, lfo_pkg::OP_MUL, 1'b1);
        send_word(SAMPLE_LO, lfo_pkg::OP_ADD, 1'b0);
        send_word(SAMPLE_HI, lfo_pkg::OP_SUB, 1'b0);
        drain();

        // Square wave stepping between the two zero points.
        reg_writes.push_back('{lfo_pkg::CFG_WAVEFORM, 32'd1});
        reg_writes.push_back('{lfo_pkg::CFG_INIT_PHASE, 32'h4000_0000});
        reg_writes.push_back('{lfo_pkg::CFG_PHASE_STEP, 32'h8000_0000});
        reg_writes.push_back('{lfo_pkg::CFG_PERIOD_LEN, 32'd3});
        apply_writes();
        send_word(SAMPLE_HI, lfo_pkg::OP_ADD, 1'b0);
        send_word(SAMPLE_HI, lfo_pkg::OP_MUL, 1'b1);
        send_word(24'sh123456, lfo_pkg::OP_SUB, 1'b0);
        send_word(SAMPLE_LO, lfo_pkg::OP_PASS, 1'b0);
        drain();

        // Period bits above the field are dropped, leaving a zero period.
        reg_writes.push_back('{lfo_pkg::CFG_PERIOD_LEN, 32'hFFF0_0000});
        reg_writes.push_back('{lfo_pkg::CFG_INIT_PHASE, 32'hC000_0000});
        apply_writes();
        send_word(SAMPLE_HI, lfo_pkg::OP_ADD, 1'b0);
        send_word(SAMPLE_LO, lfo_pkg::OP_MUL, 1'b0);
        send_word(5, lfo_pkg::OP_SUB, 1'b1);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            mode = ph % 4;
            tx_idle_pct  <= (mode == 1) ? 72 : (mode == 3) ? 19 : 0;
            rx_stall_pct <= (mode == 2) ? 72 : (mode == 3) ? 19 : 0;
            if (ph == 0) begin
                reg_writes.push_back('{lfo_pkg::CFG_PERIOD_LEN, 32'h000F_FFFF});
                reg_writes.push_back('{lfo_pkg::CFG_PHASE_STEP, 32'hFFFF_FFFF});
                reg_writes.push_back('{lfo_pkg::CFG_INIT_PHASE, 32'hFFFF_FFFF});
                reg_writes.push_back('{lfo_pkg::CFG_WAVEFORM, 32'd0});
            end else if (ph == 1) begin
                reg_writes.push_back('{lfo_pkg::CFG_PERIOD_LEN, 32'd1});
                reg_writes.push_back('{lfo_pkg::CFG_PHASE_STEP, 32'd0});
                reg_writes.push_back('{lfo_pkg::CFG_INIT_PHASE, 32'h4000_0000});
                reg_writes.push_back('{lfo_pkg::CFG_WAVEFORM, 32'hFFFF_FFFE});
            end else begin
                // Mostly short periods so that the wrap comes around often.
                r = $urandom();
                if ($urandom_range(3) != 0)
                    r[NW-1:0] = NW'($urandom_range(1, 80));
                reg_writes.push_back('{lfo_pkg::CFG_PERIOD_LEN, r});
                reg_writes.push_back('{lfo_pkg::CFG_PHASE_STEP, $urandom()});
                reg_writes.push_back('{lfo_pkg::CFG_INIT_PHASE, $urandom()});
                reg_writes.push_back('{lfo_pkg::CFG_WAVEFORM, $urandom()});
            end
            apply_writes();

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (mode == 0 && n == 6)
                    hold_req <= hold_req + 1;
                case ($urandom_range(9))
                    0:       smp = SAMPLE_HI;
                    1:       smp = SAMPLE_LO;
                    2:       smp = '0;
                    3:       smp = -1;
                    default: smp = SW'($urandom());
                endcase
                send_word(smp, lfo_pkg::t_opcode'($urandom_range(3)),
                          1'($urandom_range(1)));
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/lfo_pkg.sv
hdl/lfo_cordic.sv
hdl/lfo_sample_modulator_core.sv
hdl/lfo_checker.sv
bench/lfo_sample_modulator_checker.sv
bench/lfo_sample_modulator_core_tb.sv
